// File: src/rbsi_pkg.sv
// shared types and constants for the ray versus box slab test
package rbsi_pkg;

    // width of every coordinate and distance field on the ports
    localparam int FIELD_BITS = 32;
    localparam int NUM_AXES   = 3;

    // bit offsets of the input fields inside s_axis_tdata
    localparam int OFF_ORIGIN_X  = 0;
    localparam int OFF_ORIGIN_Y  = 32;
    localparam int OFF_ORIGIN_Z  = 64;
    localparam int OFF_DIR_X     = 96;
    localparam int OFF_DIR_Y     = 128;
    localparam int OFF_DIR_Z     = 160;
    localparam int OFF_T_START   = 192;
    localparam int OFF_T_END     = 224;
    localparam int OFF_BOX_LO_X  = 256;
    localparam int OFF_BOX_LO_YZ = 288;
    localparam int OFF_BOX_HI_X  = 352;
    localparam int OFF_BOX_HI_YZ = 384;
    localparam int IN_BITS       = 448;
    localparam int OUT_BITS      = 72;

    // side information that rides alongside the dividers
    typedef struct packed {
        logic                          alive;
        logic [NUM_AXES-1:0]           zero;
        logic [NUM_AXES-1:0]           inslab;
        logic signed [FIELD_BITS-1:0]  t0;
        logic signed [FIELD_BITS-1:0]  t1;
    } sideband_t;

    // ray interval state passed through the narrowing stages
    typedef struct packed {
        logic                               valid;
        logic                               alive;
        logic signed [FIELD_BITS-1:0]       t0;
        logic signed [FIELD_BITS-1:0]       t1;
        logic [NUM_AXES-1:0]                zero;
        logic [NUM_AXES-1:0]                inslab;
        logic [NUM_AXES-1:0][FIELD_BITS-1:0] tn;
        logic [NUM_AXES-1:0][FIELD_BITS-1:0] tf;
    } ray_state_t;

endpackage

// File: src/rbsi_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module rbsi_div_pipe #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [W+F:0]        num_mag,
    input  logic [W-1:0]        dvs_mag,
    input  logic                neg_in,
    output logic [W+F:0]        q_mag,
    output logic                neg_out
);

    localparam int N = W + F + 1;

    logic [W-1:0] rem_reg  [N];
    logic [N-1:0] numq_reg [N];
    logic [W-1:0] dvs_reg  [N];
    logic         neg_reg  [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic [W-1:0] rem_in;
            logic [N-1:0] numq_in;
            logic [W-1:0] dvs_in;
            logic         neg_in_s;
            logic [W:0]   trial;
            logic [W:0]   diff;
            logic         ge;
            logic [W-1:0] rem_next;
            logic [N-1:0] numq_next;

            if (g == 0) begin : g_first
                assign rem_in   = '0;
                assign numq_in  = num_mag;
                assign dvs_in   = dvs_mag;
                assign neg_in_s = neg_in;
            end else begin : g_rest
                assign rem_in   = rem_reg[g-1];
                assign numq_in  = numq_reg[g-1];
                assign dvs_in   = dvs_reg[g-1];
                assign neg_in_s = neg_reg[g-1];
            end

            // shift in next numerator bit, subtract divisor when it fits
            assign trial     = {rem_in, numq_in[N-1]};
            assign diff      = trial - {1'b0, dvs_in};
            assign ge        = (trial >= {1'b0, dvs_in});
            assign rem_next  = ge ? diff[W-1:0] : trial[W-1:0];
            assign numq_next = {numq_in[N-2:0], ge};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g]  <= rem_next;
                    numq_reg[g] <= numq_next;
                    dvs_reg[g]  <= dvs_in;
                    neg_reg[g]  <= neg_in_s;
                end
            end
        end
    endgenerate

    assign q_mag   = numq_reg[N-1];
    assign neg_out = neg_reg[N-1];

endmodule

// File: src/rbsi_delay.sv
// delay line matching the divider latency, with valid bits under reset
module rbsi_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             valid_in,
    input  logic [WIDTH-1:0] data_in,
    output logic             valid_out,
    output logic [WIDTH-1:0] data_out
);

    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], valid_in};
        end
    end

    // payload taps
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_tap
            always_ff @(posedge aclk) begin
                if (en) begin
                    data_reg[g] <= (g == 0) ? data_in : data_reg[(g == 0) ? 0 : g-1];
                end
            end
        end
    endgenerate

    assign valid_out = valid_reg[DEPTH-1];
    assign data_out  = data_reg[DEPTH-1];

endmodule

// File: src/rbsi_narrow.sv
// one axis of interval narrowing, registered
module rbsi_narrow #(
    parameter int AXIS = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rbsi_pkg::ray_state_t  st_in,
    output rbsi_pkg::ray_state_t  st_out
);

    rbsi_pkg::ray_state_t st_reg;
    rbsi_pkg::ray_state_t st_next;

    logic signed [rbsi_pkg::FIELD_BITS-1:0] a_val;
    logic signed [rbsi_pkg::FIELD_BITS-1:0] b_val;
    logic signed [rbsi_pkg::FIELD_BITS-1:0] near_val;
    logic signed [rbsi_pkg::FIELD_BITS-1:0] far_val;
    logic signed [rbsi_pkg::FIELD_BITS-1:0] t0_new;
    logic signed [rbsi_pkg::FIELD_BITS-1:0] t1_new;

    // order slab distances and clip the interval
    always_comb begin
        st_next  = st_in;
        a_val    = st_in.tn[AXIS];
        b_val    = st_in.tf[AXIS];
        near_val = (a_val > b_val) ? b_val : a_val;
        far_val  = (a_val > b_val) ? a_val : b_val;
        t0_new   = (near_val > st_in.t0) ? near_val : st_in.t0;
        t1_new   = (far_val < st_in.t1) ? far_val : st_in.t1;
        if (st_in.alive) begin
            if (st_in.zero[AXIS]) begin
                st_next.alive = st_in.inslab[AXIS];
            end else begin
                st_next.t0    = t0_new;
                st_next.t1    = t1_new;
                st_next.alive = (t0_new <= t1_new);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// File: src/ray_box_slab_intersect_core.sv
// top level of the ray versus axis-aligned box slab test
// Tests one ray against one box per clock cycle while the output is not stalled,
// fully pipelined. Input transactions pass through a prepare stage, the six
// restoring dividers, which retire one quotient bit per stage over
// COORD_WIDTH + FRAC_BITS + 1 quotient bits, a saturate stage, one narrowing
// stage per axis and the output register.
// A stalled output freezes the whole pipe.
// Coordinates are read from the low COORD_WIDTH bits of each field; distances
// come back sign-extended to 32 bits, and are zero on a miss.
module ray_box_slab_intersect_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_start, t_end,
    // box_lo_x, box_lo_yz, box_hi_x, box_hi_yz
    input  logic [447:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, t_enter, t_exit, zero fill
    output logic [71:0]  m_axis_tdata
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int N  = W + F + 1;
    localparam int FB = rbsi_pkg::FIELD_BITS;

    localparam logic [N-1:0] Q_POS_LIM = {{(N-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [N-1:0] Q_NEG_LIM = {{(N-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    logic en;
    logic m_valid_reg;
    logic [71:0] m_data_reg;

    // whole pipe advances unless a result is waiting and not accepted
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // field extraction
    logic signed [W-1:0] o_c  [3];
    logic signed [W-1:0] d_c  [3];
    logic signed [W-1:0] lo_c [3];
    logic signed [W-1:0] hi_c [3];
    logic signed [W-1:0] ts_c;
    logic signed [W-1:0] te_c;

    assign o_c[0]  = s_axis_tdata[rbsi_pkg::OFF_ORIGIN_X +: W];
    assign o_c[1]  = s_axis_tdata[rbsi_pkg::OFF_ORIGIN_Y +: W];
    assign o_c[2]  = s_axis_tdata[rbsi_pkg::OFF_ORIGIN_Z +: W];
    assign d_c[0]  = s_axis_tdata[rbsi_pkg::OFF_DIR_X +: W];
    assign d_c[1]  = s_axis_tdata[rbsi_pkg::OFF_DIR_Y +: W];
    assign d_c[2]  = s_axis_tdata[rbsi_pkg::OFF_DIR_Z +: W];
    assign lo_c[0] = s_axis_tdata[rbsi_pkg::OFF_BOX_LO_X +: W];
    assign lo_c[1] = s_axis_tdata[rbsi_pkg::OFF_BOX_LO_YZ + FB +: W];
    assign lo_c[2] = s_axis_tdata[rbsi_pkg::OFF_BOX_LO_YZ +: W];
    assign hi_c[0] = s_axis_tdata[rbsi_pkg::OFF_BOX_HI_X +: W];
    assign hi_c[1] = s_axis_tdata[rbsi_pkg::OFF_BOX_HI_YZ + FB +: W];
    assign hi_c[2] = s_axis_tdata[rbsi_pkg::OFF_BOX_HI_YZ +: W];
    assign ts_c    = s_axis_tdata[rbsi_pkg::OFF_T_START +: W];
    assign te_c    = s_axis_tdata[rbsi_pkg::OFF_T_END +: W];

    // prepare stage registers
    logic         prep_valid_reg;
    logic         prep_alive_reg;
    logic [N-1:0] num_reg  [6];
    logic         neg_reg  [6];
    logic [W-1:0] dvs_reg  [3];
    logic [2:0]   zero_reg;
    logic [2:0]   inslab_reg;
    logic signed [FB-1:0] t0_reg;
    logic signed [FB-1:0] t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_alive_reg <= (ts_c <= te_c);
            t0_reg         <= FB'(ts_c);
            t1_reg         <= FB'(te_c);
        end
    end

    // per axis numerators, divisor magnitude and signs
    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_axis
            logic signed [W:0] dlo;
            logic signed [W:0] dhi;
            logic signed [W:0] dd;
            logic [W:0]        dlo_abs;
            logic [W:0]        dhi_abs;
            logic [W:0]        dd_abs;
            logic              d_zero;

            assign dlo     = {lo_c[k][W-1], lo_c[k]} - {o_c[k][W-1], o_c[k]};
            assign dhi     = {hi_c[k][W-1], hi_c[k]} - {o_c[k][W-1], o_c[k]};
            assign dd      = {d_c[k][W-1], d_c[k]};
            assign dlo_abs = dlo[W] ? -dlo : dlo;
            assign dhi_abs = dhi[W] ? -dhi : dhi;
            assign dd_abs  = dd[W] ? -dd : dd;
            assign d_zero  = (d_c[k] == '0);

            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[2*k]   <= {dlo_abs, {F{1'b0}}};
                    num_reg[2*k+1] <= {dhi_abs, {F{1'b0}}};
                    neg_reg[2*k]   <= dlo[W] ^ dd[W];
                    neg_reg[2*k+1] <= dhi[W] ^ dd[W];
                    dvs_reg[k]     <= d_zero ? W'(1) : dd_abs[W-1:0];
                    zero_reg[k]    <= d_zero;
                    inslab_reg[k]  <= (o_c[k] >= lo_c[k]) && (o_c[k] <= hi_c[k]);
                end
            end
        end
    endgenerate

    // six dividers, lo and hi plane per axis
    logic [N-1:0] q_mag [6];
    logic         q_neg [6];

    genvar j;
    generate
        for (j = 0; j < 6; j++) begin : g_div
            rbsi_div_pipe #(
                .W (W),
                .F (F)
            ) u_div (
                .aclk    (aclk),
                .en      (en),
                .num_mag (num_reg[j]),
                .dvs_mag (dvs_reg[j/2]),
                .neg_in  (neg_reg[j]),
                .q_mag   (q_mag[j]),
                .neg_out (q_neg[j])
            );
        end
    endgenerate

    // side information delayed alongside the dividers
    rbsi_pkg::sideband_t sb_in;
    rbsi_pkg::sideband_t sb_out;
    logic                sb_valid;

    always_comb begin
        sb_in.alive  = prep_alive_reg;
        sb_in.zero   = zero_reg;
        sb_in.inslab = inslab_reg;
        sb_in.t0     = t0_reg;
        sb_in.t1     = t1_reg;
    end

    rbsi_delay #(
        .WIDTH ($bits(rbsi_pkg::sideband_t)),
        .DEPTH (N)
    ) u_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (prep_valid_reg),
        .data_in   (sb_in),
        .valid_out (sb_valid),
        .data_out  (sb_out)
    );

    // saturate quotients to the coordinate range
    logic signed [W-1:0] sat_w [6];

    generate
        for (j = 0; j < 6; j++) begin : g_sat
            logic [N-1:0] neg_q;
            assign neg_q = -q_mag[j];
            always_comb begin
                if (q_neg[j]) begin
                    sat_w[j] = (q_mag[j] > Q_NEG_LIM) ? {1'b1, {(W-1){1'b0}}} : neg_q[W-1:0];
                end else begin
                    sat_w[j] = (q_mag[j] > Q_POS_LIM) ? {1'b0, {(W-1){1'b1}}} : q_mag[j][W-1:0];
                end
            end
        end
    endgenerate

    rbsi_pkg::ray_state_t sat_next;
    rbsi_pkg::ray_state_t sat_reg;
    rbsi_pkg::ray_state_t st [4];

    always_comb begin
        sat_next.valid  = sb_valid;
        sat_next.alive  = sb_out.alive;
        sat_next.t0     = sb_out.t0;
        sat_next.t1     = sb_out.t1;
        sat_next.zero   = sb_out.zero;
        sat_next.inslab = sb_out.inslab;
        for (int a = 0; a < 3; a++) begin
            sat_next.tn[a] = FB'(sat_w[2*a]);
            sat_next.tf[a] = FB'(sat_w[2*a+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg.valid <= 1'b0;
        end else if (en) begin
            sat_reg <= sat_next;
        end
    end

    assign st[0] = sat_reg;

    // one narrowing stage per axis
    generate
        for (k = 0; k < 3; k++) begin : g_narrow
            rbsi_narrow #(
                .AXIS (k)
            ) u_narrow (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .st_in   (st[k]),
                .st_out  (st[k+1])
            );
        end
    endgenerate

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= st[3].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {7'b0,
                           st[3].alive ? st[3].t1 : {FB{1'b0}},
                           st[3].alive ? st[3].t0 : {FB{1'b0}},
                           st[3].alive};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // a miss carries zero distances
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[64:1] == '0)
        else $error("miss with nonzero distances");

    // a hit has an ordered interval
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |->
            $signed(m_axis_tdata[32:1]) <= $signed(m_axis_tdata[64:33]))
        else $error("hit with entry after exit");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

// File: tb/sv/tb.sv
// testbench for the ray versus axis-aligned box slab test core
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY     = 55;
    localparam int N_RANDOM    = 530;
    localparam longint CYC_MAX = 400000;
    localparam longint Q_MAX   = 64'sd2147483647;
    localparam longint Q_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] t_exit;
        logic [31:0] t_enter;
        logic        hit;
    } slab_result_t;

    typedef struct {
        logic [rbsi_pkg::IN_BITS-1:0] ray;
        bit                           typed;
        slab_result_t                 res;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [rbsi_pkg::IN_BITS-1:0]  s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [rbsi_pkg::OUT_BITS-1:0] m_axis_tdata;

    slab_result_t  pending_hits[$];
    stim_row_t     directed[$];
    int            send_idle_pct;
    int            recv_stall_pct;
    int            err_count;
    longint        cyc;

    ray_box_slab_intersect_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // saturate to the signed 32-bit range
    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // slab test predictor
    function automatic slab_result_t slab_predict(input logic [rbsi_pkg::IN_BITS-1:0] ray);
        longint org[3], dir[3], lo[3], hi[3];
        longint t0, t1, tn, tf, tmp;
        bit alive;
        slab_result_t r;
        for (int a = 0; a < 3; a++) begin
            org[a] = longint'($signed(ray[rbsi_pkg::OFF_ORIGIN_X + 32*a +: 32]));
            dir[a] = longint'($signed(ray[rbsi_pkg::OFF_DIR_X + 32*a +: 32]));
        end
        t0 = longint'($signed(ray[rbsi_pkg::OFF_T_START +: 32]));
        t1 = longint'($signed(ray[rbsi_pkg::OFF_T_END +: 32]));
        lo[0] = longint'($signed(ray[rbsi_pkg::OFF_BOX_LO_X +: 32]));
        lo[1] = longint'($signed(ray[rbsi_pkg::OFF_BOX_LO_YZ + 32 +: 32]));
        lo[2] = longint'($signed(ray[rbsi_pkg::OFF_BOX_LO_YZ +: 32]));
        hi[0] = longint'($signed(ray[rbsi_pkg::OFF_BOX_HI_X +: 32]));
        hi[1] = longint'($signed(ray[rbsi_pkg::OFF_BOX_HI_YZ + 32 +: 32]));
        hi[2] = longint'($signed(ray[rbsi_pkg::OFF_BOX_HI_YZ +: 32]));
        alive = (t0 <= t1);
        for (int a = 0; a < 3 && alive; a++) begin
            if (dir[a] == 0) begin
                alive = (org[a] >= lo[a]) && (org[a] <= hi[a]);
            end else begin
                // division truncates toward zero, as required
                tn = clamp_q(((lo[a] - org[a]) * 65536) / dir[a]);
                tf = clamp_q(((hi[a] - org[a]) * 65536) / dir[a]);
                if (tn > tf) begin
                    tmp = tn; tn = tf; tf = tmp;
                end
                if (tn > t0) t0 = tn;
                if (tf < t1) t1 = tf;
                alive = (t0 <= t1);
            end
        end
        r.hit     = alive;
        r.t_enter = alive ? t0[31:0] : 32'd0;
        r.t_exit  = alive ? t1[31:0] : 32'd0;
        return r;
    endfunction

    function automatic logic [rbsi_pkg::IN_BITS-1:0] pack_ray(
        input logic [31:0] ox, oy, oz, dx, dy, dz, ts, te,
        input logic [31:0] lx, ly, lz, hx, hy, hz);
        logic [rbsi_pkg::IN_BITS-1:0] v;
        v = '0;
        v[rbsi_pkg::OFF_ORIGIN_X +: 32]       = ox;
        v[rbsi_pkg::OFF_ORIGIN_Y +: 32]       = oy;
        v[rbsi_pkg::OFF_ORIGIN_Z +: 32]       = oz;
        v[rbsi_pkg::OFF_DIR_X +: 32]          = dx;
        v[rbsi_pkg::OFF_DIR_Y +: 32]          = dy;
        v[rbsi_pkg::OFF_DIR_Z +: 32]          = dz;
        v[rbsi_pkg::OFF_T_START +: 32]        = ts;
        v[rbsi_pkg::OFF_T_END +: 32]          = te;
        v[rbsi_pkg::OFF_BOX_LO_X +: 32]       = lx;
        v[rbsi_pkg::OFF_BOX_LO_YZ + 32 +: 32] = ly;
        v[rbsi_pkg::OFF_BOX_LO_YZ +: 32]      = lz;
        v[rbsi_pkg::OFF_BOX_HI_X +: 32]       = hx;
        v[rbsi_pkg::OFF_BOX_HI_YZ + 32 +: 32] = hy;
        v[rbsi_pkg::OFF_BOX_HI_YZ +: 32]      = hz;
        return v;
    endfunction

    // random coordinate: mostly small values, sometimes full range, extremes or zero
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
            2:       return 32'd0;
            default: return 32'($signed($urandom_range(0, 40*65536)) - 20*65536);
        endcase
    endfunction

    function automatic logic [rbsi_pkg::IN_BITS-1:0] rand_ray();
        logic [31:0] c[14];
        logic [31:0] tmp;
        for (int i = 0; i < 14; i++) c[i] = rand_coord();
        // mostly well-formed: ordered box corners and interval
        if ($urandom_range(0, 9) != 0) begin
            for (int a = 0; a < 3; a++) begin
                if ($signed(c[8+a]) > $signed(c[11+a])) begin
                    tmp = c[8+a]; c[8+a] = c[11+a]; c[11+a] = tmp;
                end
            end
            if ($signed(c[6]) > $signed(c[7])) begin
                tmp = c[6]; c[6] = c[7]; c[7] = tmp;
            end
        end
        // occasional zero direction component
        if ($urandom_range(0, 5) == 0) c[3 + $urandom_range(0, 2)] = 32'd0;
        if ($urandom_range(0, 63) == 0) return {$urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return pack_ray(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                        c[8], c[9], c[10], c[11], c[12], c[13]);
    endfunction

    // send one transaction, honoring the sender idle rate
    task automatic send_ray(input logic [rbsi_pkg::IN_BITS-1:0] ray,
                            input slab_result_t res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ray;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_hits.push_back(res);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
    endtask

    // receiver stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        slab_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[64:0];
            if (pending_hits.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected transaction: %h", m_axis_tdata);
            end else begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit || got.t_enter !== want.t_enter ||
                    got.t_exit !== want.t_exit || m_axis_tdata[71:65] !== '0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected hit=%0b enter=%h exit=%h, got %h",
                                 want.hit, want.t_enter, want.t_exit, m_axis_tdata);
                end
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [rbsi_pkg::IN_BITS-1:0] ray;
        slab_result_t       miss;
        slab_result_t       want;
        int                 mode;
        miss = '0;
        cyc = 0;
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: typed result where obvious, else predictor
        // box x 1..3, ray along x from -2 with dir 1, interval 0..10: enter 3, exit 5
        directed.push_back('{pack_ray(32'hfffe0000, 32'h8000, 32'h8000, 32'h10000, 0, 0,
            0, 32'ha0000, 32'h10000, 0, 0, 32'h30000, 32'h10000, 32'h10000), 1'b1,
            '{t_exit: 32'h50000, t_enter: 32'h30000, hit: 1'b1}});
        // inverted interval: miss
        directed.push_back('{pack_ray(0, 0, 0, 32'h10000, 32'h10000, 32'h10000,
            32'h10000, 0, 32'hffff0000, 32'hffff0000, 32'hffff0000, 32'h10000,
            32'h10000, 32'h10000), 1'b1, miss});
        // zero direction, origin outside slab: miss
        directed.push_back('{pack_ray(32'h50000, 0, 0, 0, 32'h10000, 32'h10000,
            0, 32'h7fffffff, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000), 1'b1, miss});
        // zero direction, inverted box on that axis: miss
        directed.push_back('{pack_ray(0, 0, 0, 0, 32'h10000, 32'h10000,
            32'h80000000, 32'h7fffffff, 32'h10000, 0, 0, 32'hffff0000, 32'h10000,
            32'h10000), 1'b1, miss});
        // all directions zero, origin on the faces: full interval kept
        directed.push_back('{pack_ray(32'h10000, 0, 0, 0, 0, 0, 32'h80000000,
            32'h7fffffff, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000), 1'b1,
            '{t_exit: 32'h7fffffff, t_enter: 32'h80000000, hit: 1'b1}});
        // all ones and all zeros
        directed.push_back('{'1, 1'b0, miss});
        directed.push_back('{'0, 1'b0, miss});
        // extremes that saturate the distances
        directed.push_back('{pack_ray(32'h80000000, 32'h80000000, 32'h80000000, 1, 1,
            32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0, miss});
        directed.push_back('{pack_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff), 1'b0, miss});
        // inverted box with nonzero direction
        directed.push_back('{pack_ray(0, 0, 0, 32'hffff0000, 32'h20000, 32'h8000,
            32'hfff00000, 32'h100000, 32'h30000, 32'h30000, 32'h30000, 32'h10000,
            32'h10000, 32'h10000), 1'b0, miss});
        // negative directions through a box
        directed.push_back('{pack_ray(32'h50000, 32'h50000, 32'h50000, 32'hffff0000,
            32'hfffe0000, 32'hfffc0000, 0, 32'h640000, 0, 0, 0, 32'h10000,
            32'h10000, 32'h10000), 1'b0, miss});
        // grazing a face: single-point interval that still counts as a hit
        directed.push_back('{pack_ray(0, 32'h10000, 0, 32'h10000, 0, 32'h10000,
            0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000,
            32'h20000), 1'b0, miss});
        for (int i = 0; i < directed.size(); i++) begin
            want = directed[i].typed ? directed[i].res : slab_predict(directed[i].ray);
            send_ray(directed[i].ray, want);
        end
        // hold off until every result has come back
        drain();

        // random phases with different idle and stall rates
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = (n * 5) / N_RANDOM;
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            ray = rand_ray();
            send_ray(ray, slab_predict(ray));
        end
        drain();
        recv_stall_pct = 0;
        repeat (LATENCY + 10) @(posedge aclk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/rbsi_pkg.sv
src/rbsi_div_pipe.sv
src/rbsi_delay.sv
src/rbsi_narrow.sv
src/ray_box_slab_intersect_core.sv
tb/sv/tb.sv
